// File: design/stepper_step_dir_pulse_generator_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef STEPPER_STEP_DIR_PULSE_GENERATOR_UNIT_ASSERT_SVH
`define STEPPER_STEP_DIR_PULSE_GENERATOR_UNIT_ASSERT_SVH

// cond holds in a cycle -> prop holds in the same cycle
`define STEPGEN_ASSERT_NOW(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("stepgen check failed");

// cond holds in a cycle -> prop holds in the next cycle
`define STEPGEN_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("stepgen check failed");

`endif

// File: design/stepgen_pkg.sv
`default_nettype none

package stepgen_pkg;

    localparam int POS_WIDTH   = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int STEP_WIDTH  = 32;
    localparam int TICK_WIDTH  = 16;
    localparam int CFG_WIDTH   = 16;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd10;
    localparam logic [15:0] STEPS_LAP_RESET   = 16'd200;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_STEPS = 2'd1,
        FUNC_LAPS  = 2'd2,
        FUNC_HOME  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_DIR_FORWARD = 2'd0,
        REG_HALF_PERIOD = 2'd1,
        REG_STEPS_LAP   = 2'd2,
        REG_ENABLE_ON   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        func_t                  func;
        logic [COUNT_WIDTH-1:0] count;
    } cmd_t;

    typedef struct packed {
        logic                        step_out;
        logic                        dir_out;
        logic                        enable_n_out;
        logic                        busy_res;
        logic                        accepted;
        logic signed [POS_WIDTH-1:0] position;
    } res_t;

    typedef struct packed {
        logic        dir_forward;
        logic [15:0] half_period_ticks;
        logic [15:0] steps_per_lap;
        logic        enable_on;
    } cfg_regs_t;

endpackage

`default_nettype wire

// File: design/stepgen_cfg.sv
`default_nettype none

module stepgen_cfg (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire stepgen_pkg::cfg_reg_t                cfg_index,
    input  wire logic [stepgen_pkg::CFG_WIDTH-1:0]    cfg_data,
    output stepgen_pkg::cfg_regs_t                    regs
);

    stepgen_pkg::cfg_regs_t regs_reg;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.dir_forward       <= 1'b1;
            regs_reg.half_period_ticks <= stepgen_pkg::HALF_PERIOD_RESET;
            regs_reg.steps_per_lap     <= stepgen_pkg::STEPS_LAP_RESET;
            regs_reg.enable_on         <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                stepgen_pkg::REG_DIR_FORWARD: regs_reg.dir_forward       <= cfg_data[0];
                stepgen_pkg::REG_HALF_PERIOD: regs_reg.half_period_ticks <= cfg_data[15:0];
                stepgen_pkg::REG_STEPS_LAP:   regs_reg.steps_per_lap     <= cfg_data[15:0];
                stepgen_pkg::REG_ENABLE_ON:   regs_reg.enable_on         <= cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/stepgen_core.sv
`default_nettype none

module stepgen_core (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire stepgen_pkg::cfg_regs_t regs,
    input  wire logic                   req_valid,
    output logic                        req_ready,
    input  wire stepgen_pkg::cmd_t      req,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output stepgen_pkg::res_t           res
);

    localparam int PW = stepgen_pkg::POS_WIDTH;
    localparam int SW = stepgen_pkg::STEP_WIDTH;
    localparam int TW = stepgen_pkg::TICK_WIDTH;

    logic signed [PW-1:0] pos_reg,   pos_next;
    logic [SW-1:0]        rem_reg,   rem_next;
    logic                 phase_reg, phase_next;
    logic [TW-1:0]        tick_reg,  tick_next;
    logic                 adir_reg,  adir_next;
    logic                 res_valid_reg;
    stepgen_pkg::res_t    res_reg,   res_next;

    logic                 fire;
    logic                 busy;
    logic                 busy_after;
    logic                 acc;
    logic [TW-1:0]        half;
    logic [TW-1:0]        tick_inc;
    logic [SW-1:0]        rem_dec;
    logic [SW-1:0]        lap_steps;
    logic [SW-1:0]        move_n;
    logic [PW-1:0]        home_mag;

    assign req_ready = !res_valid_reg || res_ready;
    assign fire      = req_valid && req_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign busy      = rem_reg != '0;
    assign half      = (regs.half_period_ticks == '0) ? TW'(1) : regs.half_period_ticks;
    assign tick_inc  = tick_reg + TW'(1);
    assign rem_dec   = rem_reg - SW'(1);
    // 16x16 product always fits the 32-bit step counter
    assign lap_steps = {16'b0, req.count} * {16'b0, regs.steps_per_lap};
    assign home_mag  = pos_reg[PW-1] ? PW'(-pos_reg) : PW'(pos_reg);

    always_comb
    begin
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        adir_next  = adir_reg;
        acc        = 1'b0;
        move_n     = SW'(req.count);

        if (req.func == stepgen_pkg::FUNC_TICK)
        begin
            if (busy)
            begin
                if (tick_inc >= half)
                begin
                    tick_next = '0;
                    if (phase_reg)
                    begin
                        phase_next = 1'b0;
                    end
                    else
                    begin
                        rem_next   = rem_dec;
                        phase_next = rem_dec != '0;
                    end
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
        end
        else if (!busy)
        begin
            acc       = 1'b1;
            tick_next = '0;
            unique case (req.func)
                stepgen_pkg::FUNC_HOME:
                begin
                    pos_next   = '0;
                    adir_next  = pos_reg[PW-1];
                    rem_next   = SW'(home_mag);
                    phase_next = home_mag != '0;
                end
                default:
                begin
                    if (req.func == stepgen_pkg::FUNC_LAPS)
                    begin
                        move_n = lap_steps;
                    end
                    if (regs.dir_forward)
                    begin
                        pos_next = pos_reg + PW'(move_n);
                    end
                    else
                    begin
                        pos_next = pos_reg - PW'(move_n);
                    end
                    adir_next  = regs.dir_forward;
                    rem_next   = move_n;
                    phase_next = move_n != '0;
                end
            endcase
        end
    end

    always_comb
    begin
        busy_after            = rem_next != '0;
        res_next.step_out     = busy_after && phase_next;
        res_next.dir_out      = busy_after ? adir_next : regs.dir_forward;
        res_next.enable_n_out = !regs.enable_on;
        res_next.busy_res     = busy_after;
        res_next.accepted     = acc;
        res_next.position     = pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            rem_reg       <= '0;
            phase_reg     <= 1'b0;
            tick_reg      <= '0;
            adir_reg      <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                pos_reg   <= pos_next;
                rem_reg   <= rem_next;
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                adir_reg  <= adir_next;
            end
            if (req_ready)
            begin
                res_valid_reg <= req_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

// File: design/stepper_step_dir_pulse_generator_unit.sv
// Step/direction pulse generator with a signed 32-bit position counter. Each request on
// the cmd channel is a tick or a command (move steps, move laps, return to zero) and
// yields exactly one result on the res channel. The block takes one request per clock
// while the res channel does not stall. A request passes through the input register, then
// through the state update, which holds a 16x16 lap multiplier feeding the position adder,
// into the result register. A stalled res channel holds the pipeline; the input register still
// takes one request while the result waits. Configuration writes are registered and are
// meant to happen while no request is in flight.
`default_nettype none

module stepper_step_dir_pulse_generator_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cmd_valid,
    output logic                                   cmd_ready,
    input  wire stepgen_pkg::cmd_t                 cmd,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output stepgen_pkg::res_t                      res,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire stepgen_pkg::cfg_reg_t             cfg_index,
    input  wire logic [stepgen_pkg::CFG_WIDTH-1:0] cfg_data
);

    stepgen_pkg::cfg_regs_t regs;
    stepgen_pkg::cmd_t      cmd_reg;
    logic                   cmd_valid_reg;
    logic                   core_ready;

    assign cmd_ready = !cmd_valid_reg || core_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            cmd_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
        begin
            cmd_reg <= cmd;
        end
    end

    stepgen_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    stepgen_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (regs),
        .req_valid (cmd_valid_reg),
        .req_ready (core_ready),
        .req       (cmd_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

`default_nettype wire

// File: design/stepgen_checker.sv
`default_nettype none

`include "stepper_step_dir_pulse_generator_unit_assert.svh"

module stepgen_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              cmd_ready,
    input wire logic              res_valid,
    input wire logic              res_ready,
    input wire stepgen_pkg::res_t res
);

    // a stalled result stays put
    `STEPGEN_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))

    // no step pulse once the move is over
    `STEPGEN_ASSERT_NOW(a_idle_step_low, res_valid && !res.busy_res, !res.step_out)

    // with the result register empty the input side must be open
    `STEPGEN_ASSERT_NOW(a_ready_when_empty, !res_valid, cmd_ready)

    // an accepted command with pulses pending starts in the high phase
    `STEPGEN_ASSERT_NOW(a_start_high, res_valid && res.accepted && res.busy_res, res.step_out)

endmodule

bind stepper_step_dir_pulse_generator_unit stepgen_checker u_stepgen_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

`default_nettype wire

// File: bench/stepper_step_dir_pulse_generator_unit_test.sv
`timescale 1ns / 1ps

module stepper_step_dir_pulse_generator_unit_test;

    import stepgen_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cmd_valid = 1'b0;
    logic                 cmd_ready;
    cmd_t                 cmd = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    res_t                 res;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_reg_t             cfg_index = REG_DIR_FORWARD;
    logic [CFG_WIDTH-1:0] cfg_data = '0;

    stepper_step_dir_pulse_generator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // requests waiting to go out, pin states still owed by the block
    cmd_t pending_cmds[$];
    res_t due_pin_states[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int requests_sent = 0;
    int moves_taken = 0;
    int homes_taken = 0;
    int cmds_dropped = 0;

    // predictor copy of the registers
    logic        reg_dir = 1'b1;
    logic [15:0] reg_half = HALF_PERIOD_RESET;
    logic [15:0] reg_lap = STEPS_LAP_RESET;
    logic        reg_en = 1'b0;

    // predictor copy of the motion state
    logic [31:0] pos_count = '0;
    logic [31:0] steps_left = '0;
    logic        high_phase = 1'b0;
    logic [15:0] tick_cnt = '0;
    logic        move_dir = 1'b1;

    function automatic res_t next_pin_state(cmd_t c);
        res_t        r;
        logic [15:0] hp;
        logic [31:0] n;
        logic        took;
        took = 1'b0;
        if (c.func == FUNC_TICK)
        begin
            if (steps_left != 0)
            begin
                hp = (reg_half == 16'd0) ? 16'd1 : reg_half;
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= hp)
                begin
                    tick_cnt = '0;
                    if (high_phase)
                    begin
                        high_phase = 1'b0;
                    end
                    else
                    begin
                        steps_left = steps_left - 32'd1;
                        high_phase = (steps_left != 0);
                    end
                end
            end
        end
        else if (steps_left != 0)
        begin
            cmds_dropped++;
        end
        else
        begin
            took = 1'b1;
            if (c.func == FUNC_HOME)
            begin
                // negative position walks forward back to zero
                move_dir = pos_count[31];
                n = pos_count[31] ? 32'd0 - pos_count : pos_count;
                pos_count = '0;
                homes_taken++;
            end
            else
            begin
                n = (c.func == FUNC_STEPS) ? 32'(c.count) : 32'(c.count) * 32'(reg_lap);
                pos_count = reg_dir ? pos_count + n : pos_count - n;
                move_dir = reg_dir;
                moves_taken++;
            end
            steps_left = n;
            tick_cnt = '0;
            high_phase = (n != 0);
        end
        r.step_out = (steps_left != 0) && high_phase;
        r.dir_out = (steps_left != 0) ? move_dir : reg_dir;
        r.enable_n_out = ~reg_en;
        r.busy_res = (steps_left != 0);
        r.accepted = took;
        r.position = pos_count;
        return r;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd <= '0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                due_pin_states.push_back(next_pin_state(cmd));
                requests_sent++;
            end
            if (!cmd_valid || cmd_ready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cmd_valid <= 1'b1;
                    cmd <= pending_cmds.pop_front();
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (due_pin_states.size() == 0)
                begin
                    $error("result with no request outstanding: %p", res);
                    fail_count++;
                end
                else
                begin
                    want = due_pin_states.pop_front();
                    if (res.step_out !== want.step_out)
                    begin
                        $error("step_out: expected %0d, got %0d", want.step_out, res.step_out);
                        fail_count++;
                    end
                    if (res.dir_out !== want.dir_out)
                    begin
                        $error("dir_out: expected %0d, got %0d", want.dir_out, res.dir_out);
                        fail_count++;
                    end
                    if (res.enable_n_out !== want.enable_n_out)
                    begin
                        $error("enable_n_out: expected %0d, got %0d",
                               want.enable_n_out, res.enable_n_out);
                        fail_count++;
                    end
                    if (res.busy_res !== want.busy_res)
                    begin
                        $error("busy_res: expected %0d, got %0d", want.busy_res, res.busy_res);
                        fail_count++;
                    end
                    if (res.accepted !== want.accepted)
                    begin
                        $error("accepted: expected %0d, got %0d", want.accepted, res.accepted);
                        fail_count++;
                    end
                    if (res.position !== want.position)
                    begin
                        $error("position: expected %0d, got %0d", want.position, res.position);
                        fail_count++;
                    end
                end
            end
            res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        unique case (idx)
            REG_DIR_FORWARD: reg_dir = val[0];
            REG_HALF_PERIOD: reg_half = val;
            REG_STEPS_LAP:   reg_lap = val;
            REG_ENABLE_ON:   reg_en = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic dir, logic [15:0] hp, logic [15:0] lap, logic en);
        write_reg(REG_DIR_FORWARD, {15'd0, dir});
        write_reg(REG_HALF_PERIOD, hp);
        write_reg(REG_STEPS_LAP, lap);
        write_reg(REG_ENABLE_ON, {15'd0, en});
    endtask

    task automatic push_cmd(func_t f, logic [15:0] n);
        cmd_t c;
        c.func = f;
        c.count = n;
        pending_cmds.push_back(c);
    endtask

    // sample on the falling edge so the driver's queue pops have settled
    task automatic wait_idle();
        do @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_valid || due_pin_states.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // mostly ticks; moves stay short so they finish and later commands get through
    task automatic queue_random_traffic(int n_items);
        int   pick;
        cmd_t c;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            c.count = 16'($urandom_range(0, 65535));
            if (pick < 62)
            begin
                c.func = FUNC_TICK;
            end
            else if (pick < 82)
            begin
                c.func = FUNC_STEPS;
                c.count = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(8, 40))
                                                      : 16'($urandom_range(0, 7));
            end
            else if (pick < 92)
            begin
                c.func = FUNC_LAPS;
                c.count = 16'($urandom_range(0, 4));
            end
            else
            begin
                c.func = FUNC_HOME;
            end
            pending_cmds.push_back(c);
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int n_items);
        @(negedge clk);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        queue_random_traffic(n_items);
        wait_idle();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        set_config(1'b1, 16'd1, 16'd2, 1'b0);
        push_cmd(FUNC_TICK, 16'hFFFF);   // tick while idle
        push_cmd(FUNC_HOME, 16'h0000);   // return while already at zero
        push_cmd(FUNC_STEPS, 16'h0000);  // zero steps
        push_cmd(FUNC_STEPS, 16'd2);
        push_cmd(FUNC_STEPS, 16'd5);     // dropped, still stepping
        repeat (4) push_cmd(FUNC_TICK, 16'h5555);
        push_cmd(FUNC_LAPS, 16'd1);
        push_cmd(FUNC_HOME, 16'hAAAA);   // dropped
        repeat (4) push_cmd(FUNC_TICK, 16'h0000);
        push_cmd(FUNC_TICK, 16'h8001);
        push_cmd(FUNC_HOME, 16'h0000);   // reverse back from +4
        repeat (8) push_cmd(FUNC_TICK, 16'h7FFE);
        wait_idle();

        set_config(1'b1, 16'd1, 16'd3, 1'b1);
        run_phase(0, 0, 195);
        set_config(1'b0, 16'd2, 16'd1, 1'b0);
        run_phase(76, 0, 195);
        // zero half period acts as one tick, zero lap size gives empty moves
        set_config(1'b1, 16'd0, 16'd0, 1'b1);
        run_phase(0, 76, 195);
        set_config(1'b0, 16'd3, 16'd2, 1'b0);
        run_phase(26, 26, 195);

        // let any move in progress run out before the long one
        while (steps_left != 0)
        begin
            repeat (64) push_cmd(FUNC_TICK, 16'($urandom_range(0, 65535)));
            wait_idle();
        end

        // full-scale lap move wraps the position; it never completes
        set_config(1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
        push_cmd(FUNC_LAPS, 16'hFFFF);
        repeat (3) push_cmd(FUNC_TICK, 16'h0000);
        push_cmd(FUNC_STEPS, 16'hFFFF);
        push_cmd(FUNC_HOME, 16'hFFFF);
        wait_idle();
        // shorter half period lands mid-move and applies right away
        write_reg(REG_HALF_PERIOD, 16'd1);
        write_reg(REG_DIR_FORWARD, 16'd0);
        repeat (6) push_cmd(FUNC_TICK, 16'h1234);
        wait_idle();
        repeat (8) @(posedge clk);

        $display("Sent %0d requests through four handshake pacing mixes plus directed cases;",
                 requests_sent);
        $display("%0d moves and %0d returns to zero taken, %0d commands dropped while busy.",
                 moves_taken, homes_taken, cmds_dropped);
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
